// ===== src/fcurve_pkg.sv =====
// Shared types, constants and controller/datapath signal groups for the fan-curve interpolator.
package fcurve_pkg;

    localparam int TEMP_W  = 8;
    localparam int SPEED_W = 7;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;
    localparam int PROD_W  = TEMP_W + SPEED_W;
    localparam int DIVC_W  = $clog2(PROD_W);

    localparam int DEFAULT_MAX_POINTS = 16;

    localparam logic [SPEED_W-1:0] SPEED_LIMIT = SPEED_W'(100);

    // APB register map
    localparam int             APB_DATA_W      = 32;
    localparam int             APB_ADDR_W      = 3;
    localparam logic [0:0]     REG_POINT_COUNT = 1'b0;

    // action codes
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // status codes
    localparam logic STS_OK       = 1'b0;
    localparam logic STS_REJECTED = 1'b1;

    typedef struct packed {
        logic               action;
        logic [INDEX_W-1:0] point_index;
        logic [TEMP_W-1:0]  point_temperature;
        logic [SPEED_W-1:0] point_pct;
        logic [TEMP_W-1:0]  temperature;
    } t_in_item;

    typedef struct packed {
        logic [SPEED_W-1:0] fan_pct;
        logic               status;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic write;
        logic res_load;
        logic res_zero;
        logic scan_init;
        logic rd;
        logic chk;
        logic clamp;
        logic seg;
        logic div_step;
        logic apply;
        logic out_load;
    } t_ctl_cmd;

    typedef struct packed {
        logic is_sample;
        logic count_zero;
        logic seg_hit;
        logic last;
        logic seg_edge;
        logic div_last;
        logic out_free;
    } t_ctl_sts;

endpackage

// ===== src/fcurve_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fcurve_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/fcurve_ctrl.sv =====
// Sequencer for the fan-curve interpolator: decode, table scan, divide, result hand-off.
module fcurve_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fcurve_pkg::t_ctl_sts i_sts,
    output fcurve_pkg::t_ctl_cmd o_cmd
);

    import fcurve_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD,
        S_CHK,
        S_CLAMP,
        S_SEG,
        S_DIV,
        S_APPLY,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_stall;
    logic   n_in_stall;

    always_comb begin
        n_state    = r_state;
        n_in_stall = r_in_stall;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                    n_in_stall    = 1'b1;
                end
            end
            S_DECODE: begin
                if (!i_sts.is_sample) begin
                    o_cmd.write    = 1'b1;
                    o_cmd.res_load = 1'b1;
                    n_state        = S_FIN;
                end else if (i_sts.count_zero) begin
                    o_cmd.res_zero = 1'b1;
                    n_state        = S_FIN;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CHK;
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                if (i_sts.seg_hit) begin
                    n_state = S_SEG;
                end else if (i_sts.last) begin
                    n_state = S_CLAMP;
                end else begin
                    n_state = S_RD;
                end
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = S_FIN;
            end
            S_SEG: begin
                o_cmd.seg = 1'b1;
                n_state   = i_sts.seg_edge ? S_FIN : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                    n_in_stall     = 1'b0;
                end
            end
            default: begin
                n_state    = S_IDLE;
                n_in_stall = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_stall <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_stall <= n_in_stall;
        end
    end

    assign o_in_stall = r_in_stall;

endmodule

// ===== src/fcurve_dp.sv =====
// Datapath: curve table, segment scan registers, multiplier, serial divider, output register.
module fcurve_dp #(
    parameter int MAX_CURVE_POINTS = fcurve_pkg::DEFAULT_MAX_POINTS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fcurve_pkg::t_in_item              i_in,
    input  logic [fcurve_pkg::COUNT_W-1:0]    i_point_count,
    input  fcurve_pkg::t_ctl_cmd              i_cmd,
    output fcurve_pkg::t_ctl_sts              o_sts,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output fcurve_pkg::t_out_item             o_out
);

    import fcurve_pkg::*;

    localparam int AW = $clog2(MAX_CURVE_POINTS);
    localparam int NW = $clog2(MAX_CURVE_POINTS + 1);
    localparam int CW = (NW > COUNT_W) ? NW : COUNT_W;
    localparam int LW = (NW > INDEX_W) ? NW : INDEX_W;
    localparam int EW = TEMP_W + SPEED_W;

    localparam logic [CW-1:0] MAX_C = CW'(MAX_CURVE_POINTS);
    localparam logic [LW-1:0] MAX_L = LW'(MAX_CURVE_POINTS);

    t_in_item                   r_item;
    logic [MAX_CURVE_POINTS-1:0] r_valid;
    logic                       r_rd_valid;
    logic [NW-1:0]              r_idx;
    logic [TEMP_W-1:0]          r_first_t;
    logic [SPEED_W-1:0]         r_first_s;
    logic [TEMP_W-1:0]          r_prev_t;
    logic [SPEED_W-1:0]         r_prev_s;
    logic [TEMP_W-1:0]          r_t1;
    logic [SPEED_W-1:0]         r_s1;
    logic [TEMP_W-1:0]          r_t2;
    logic [SPEED_W-1:0]         r_s2;
    logic [PROD_W-1:0]          r_prod;
    logic                       r_neg;
    logic [TEMP_W-1:0]          r_den;
    logic [TEMP_W-1:0]          r_rem;
    logic [PROD_W-1:0]          r_quot;
    logic [DIVC_W-1:0]          r_div_cnt;
    logic [SPEED_W-1:0]         r_speed;
    logic                       r_status;
    t_out_item                  r_out;
    logic                       r_out_valid;

    logic [CW-1:0]      pc_ext;
    logic [NW-1:0]      n_eff;
    logic [LW-1:0]      lidx;
    logic               idx_ok;
    logic               spd_ok;
    logic               wr_en;
    logic [AW-1:0]      rd_addr;
    logic [EW-1:0]      rd_data;
    logic [TEMP_W-1:0]  cur_t;
    logic [SPEED_W-1:0] cur_s;
    logic [TEMP_W-1:0]  t;
    logic               hit;
    logic               seg_edge;
    logic [TEMP_W-1:0]  dt;
    logic               neg;
    logic [SPEED_W-1:0] ads;
    logic [PROD_W-1:0]  prod;
    logic [TEMP_W:0]    rem_sh;
    logic [TEMP_W:0]    rem_sub;
    logic               ge;
    logic [SPEED_W:0]   sum;
    logic               out_free;

    // count register above the table depth acts as the depth
    assign pc_ext = CW'(i_point_count);
    assign n_eff  = (pc_ext > MAX_C) ? NW'(MAX_C) : NW'(pc_ext);

    assign lidx   = LW'(r_item.point_index);
    assign idx_ok = lidx < MAX_L;
    assign spd_ok = r_item.point_pct <= SPEED_LIMIT;
    assign wr_en  = i_cmd.write && spd_ok && idx_ok;
    assign rd_addr = r_idx[AW-1:0];

    fcurve_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_CURVE_POINTS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (lidx[AW-1:0]),
        .i_wr_data ({r_item.point_temperature, r_item.point_pct}),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // never-written entries read as the cleared value
    assign cur_t = r_rd_valid ? rd_data[EW-1:SPEED_W] : '0;
    assign cur_s = r_rd_valid ? rd_data[SPEED_W-1:0] : '0;
    assign t     = r_item.temperature;

    assign hit      = (r_idx != '0) && (t >= r_prev_t) && (t <= cur_t);
    assign seg_edge = (t <= r_t1) || (t >= r_t2);

    assign dt   = t - r_t1;
    assign neg  = r_s2 < r_s1;
    assign ads  = neg ? (r_s1 - r_s2) : (r_s2 - r_s1);
    assign prod = PROD_W'(dt) * PROD_W'(ads);

    // restoring divide, one quotient bit per step
    assign rem_sh  = {r_rem, r_prod[PROD_W-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    assign sum = r_neg ? ({1'b0, r_s1} - {1'b0, r_quot[SPEED_W-1:0]})
                       : ({1'b0, r_s1} + {1'b0, r_quot[SPEED_W-1:0]});

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (wr_en) begin
                r_valid[lidx[AW-1:0]] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in;
        end
        if (i_cmd.res_load) begin
            r_speed  <= '0;
            r_status <= spd_ok ? STS_OK : STS_REJECTED;
        end
        if (i_cmd.res_zero) begin
            r_speed  <= '0;
            r_status <= STS_OK;
        end
        if (i_cmd.scan_init) begin
            r_idx <= '0;
        end
        if (i_cmd.rd) begin
            r_rd_valid <= r_valid[rd_addr];
        end
        if (i_cmd.chk) begin
            if (r_idx == '0) begin
                r_first_t <= cur_t;
                r_first_s <= cur_s;
            end
            if (hit) begin
                r_t1 <= r_prev_t;
                r_s1 <= r_prev_s;
                r_t2 <= cur_t;
                r_s2 <= cur_s;
            end
            r_prev_t <= cur_t;
            r_prev_s <= cur_s;
            r_idx    <= NW'(r_idx + NW'(1));
        end
        if (i_cmd.clamp) begin
            r_speed  <= (t < r_first_t) ? r_first_s : r_prev_s;
            r_status <= STS_OK;
        end
        if (i_cmd.seg) begin
            r_status  <= STS_OK;
            r_speed   <= (t <= r_t1) ? r_s1 : r_s2;
            r_prod    <= prod;
            r_neg     <= neg;
            r_den     <= r_t2 - r_t1;
            r_rem     <= '0;
            r_quot    <= '0;
            r_div_cnt <= DIVC_W'(PROD_W - 1);
        end
        if (i_cmd.div_step) begin
            r_rem     <= ge ? rem_sub[TEMP_W-1:0] : rem_sh[TEMP_W-1:0];
            r_quot    <= {r_quot[PROD_W-2:0], ge};
            r_prod    <= {r_prod[PROD_W-2:0], 1'b0};
            r_div_cnt <= r_div_cnt - DIVC_W'(1);
        end
        if (i_cmd.apply) begin
            r_speed <= sum[SPEED_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_out.fan_pct <= r_speed;
            r_out.status  <= r_status;
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.is_sample  = r_item.action == ACT_SAMPLE;
        o_sts.count_zero = n_eff == '0;
        o_sts.seg_hit    = hit;
        o_sts.last       = NW'(r_idx + NW'(1)) == n_eff;
        o_sts.seg_edge   = seg_edge;
        o_sts.div_last   = r_div_cnt == '0;
        o_sts.out_free   = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== src/fan_curve_interpolator_unit.sv =====
// Top level of the fan-curve interpolator: APB register, sequencer and datapath.
//
//   channel   direction  handshake                word
//   --------  ---------  -----------------------  ----------------------------------
//   in        input      i_in_valid/o_in_stall    load point or temperature sample
//   out       output     o_out_valid/i_out_stall  fan percent and load status
//   config    APB        psel/penable/pready      point_count at byte address 0
//
// One word is in flight at a time. A load is decoded, written to the table if its
// speed is within the limit, and handed to the output register. A sample with no
// points in use answers 0; else it scans the points in use, one RAM read and one
// compare per point, and then clamps (no segment holds it), takes the speed at an
// end of the segment that holds it, or is interpolated there (15-step serial
// divide). The input opens again in the cycle after the result is handed to the output register.
// Reset is synchronous, active low; it clears the table valid bits, so every
// point reads as zero until loaded. A stalled output holds its word; the next
// input word is taken while a finished word waits in the output register.
module fan_curve_interpolator_unit #(
    parameter int MAX_CURVE_POINTS = fcurve_pkg::DEFAULT_MAX_POINTS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  fcurve_pkg::t_in_item               i_in,
    // output channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output fcurve_pkg::t_out_item              o_out,
    // APB config port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fcurve_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [fcurve_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [fcurve_pkg::APB_DATA_W-1:0]  prdata,
    output logic                               pready
);

    import fcurve_pkg::*;

    logic [COUNT_W-1:0] r_point_count;
    logic               cfg_wr;
    t_ctl_cmd           cmd;
    t_ctl_sts           sts;

    // Register index is paddr[2]; byte lanes below it are ignored.
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
        end else if (cfg_wr && (paddr[2] == REG_POINT_COUNT)) begin
            r_point_count <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_POINT_COUNT) begin
            prdata = APB_DATA_W'(r_point_count);
        end
    end

    // Sequencer: owns the input handshake and steps the datapath.
    fcurve_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: table RAM, scan, multiply, divide and output register.
    fcurve_dp #(
        .MAX_CURVE_POINTS (MAX_CURVE_POINTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_point_count (r_point_count),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out         (o_out)
    );

    // After a word is taken the input stalls until its result is handed off.
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    // A rejected load never carries a fan percent.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status == STS_REJECTED)) |-> (o_out.fan_pct == '0))
        else $error("rejected load with nonzero speed");

    // Interpolation stays within stored points, all of which are limited.
    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.fan_pct <= SPEED_LIMIT))
        else $error("fan percent above limit");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for fan_curve_interpolator_unit: directed table, random curves, APB writes.
module tb_top;
    import fcurve_pkg::*;

    localparam int NPTS           = DEFAULT_MAX_POINTS;
    localparam int IN_W           = $bits(t_in_item);
    localparam int WATCHDOG_LIMIT = 2000;  // idle cycles; worst word plus the long hold fits easily
    localparam int DRAIN_CYCLES   = 64;    // longer than a full 16-point scan plus divide
    localparam int HOLD_AFTER     = 300;   // output words seen before the long receiver hold
    localparam int HOLD_CYCLES    = 400;
    localparam int RAND_PHASES    = 10;
    localparam int PHASE_WORDS    = 105;
    localparam logic [APB_ADDR_W-1:0] COUNT_ADDR = APB_ADDR_W'(4 * REG_POINT_COUNT);

    typedef enum logic {ROW_WORD, ROW_COUNT} t_row_kind;

    // one directed step: either an input word or a point_count write
    typedef struct {
        t_row_kind          kind;
        t_in_item           word;
        logic               typed;   // want holds a hand-written result
        t_out_item          want;
        logic [COUNT_W-1:0] count;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // shadow copy of the curve table and the point_count register
    logic [TEMP_W-1:0]  curve_temp  [NPTS];
    logic [SPEED_W-1:0] curve_speed [NPTS];
    logic [COUNT_W-1:0] curve_count;

    t_out_item due_words [$];   // predicted output words, oldest first
    t_row      dir_rows  [$];
    int        mismatches  = 0;
    int        words_seen  = 0;
    int        idle_cycles = 0;
    bit        no_idle     = 1'b0;  // both sides run flat out while set

    fan_curve_interpolator_unit #(
        .MAX_CURVE_POINTS(NPTS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Fan percent for temperature t over the points in use. First segment
    // whose inclusive bounds hold t wins; falling segments never hold t.
    function automatic logic [SPEED_W-1:0] curve_eval(logic [TEMP_W-1:0] t);
        int n;
        int tt;
        int t1;
        int t2;
        int s1;
        int s2;
        n  = (curve_count > NPTS) ? NPTS : int'(curve_count);
        tt = t;
        if (n == 0) return '0;
        if (n == 1) return curve_speed[0];
        for (int i = 0; i + 1 < n; i++) begin
            t1 = curve_temp[i];
            t2 = curve_temp[i+1];
            s1 = curve_speed[i];
            s2 = curve_speed[i+1];
            if (tt >= t1 && tt <= t2) begin
                if (tt <= t1) return SPEED_W'(s1);   // also covers t1 == t2
                if (tt >= t2) return SPEED_W'(s2);
                // SV integer divide truncates toward zero, as required
                return SPEED_W'(s1 + ((tt - t1) * (s2 - s1)) / (t2 - t1));
            end
        end
        if (tt < curve_temp[0]) return curve_speed[0];
        return curve_speed[n-1];
    endfunction

    // Result of one accepted word; loads update the shadow table.
    function automatic t_out_item curve_step(t_in_item w);
        t_out_item r;
        r.fan_pct = '0;
        r.status  = STS_OK;
        if (w.action == ACT_LOAD) begin
            if (w.point_pct > SPEED_LIMIT) begin
                r.status = STS_REJECTED;
            end else if (int'(w.point_index) < NPTS) begin
                curve_temp[w.point_index]  = w.point_temperature;
                curve_speed[w.point_index] = w.point_pct;
            end
        end else begin
            r.fan_pct = curve_eval(w.temperature);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------

    // every load answers speed 0; the caller gives the expected status
    function automatic t_row load_row(int idx, int tp, int sp, logic sts);
        t_row r;
        r.kind                   = ROW_WORD;
        r.word.action            = ACT_LOAD;
        r.word.point_index       = INDEX_W'(idx);
        r.word.point_temperature = TEMP_W'(tp);
        r.word.point_pct         = SPEED_W'(sp);
        r.word.temperature       = 8'hA5;
        r.typed                  = 1'b1;
        r.want.fan_pct           = '0;
        r.want.status            = sts;
        r.count                  = '0;
        return r;
    endfunction

    // point fields all ones so unused bits toggle against the sample
    function automatic t_row sample_row(int t, logic typed, int sp);
        t_row r;
        r.kind                   = ROW_WORD;
        r.word.action            = ACT_SAMPLE;
        r.word.point_index       = '1;
        r.word.point_temperature = '1;
        r.word.point_pct         = '1;
        r.word.temperature       = TEMP_W'(t);
        r.typed                  = typed;
        r.want.fan_pct           = SPEED_W'(sp);
        r.want.status            = STS_OK;
        r.count                  = '0;
        return r;
    endfunction

    function automatic t_row count_row(int n);
        t_row r;
        r.kind  = ROW_COUNT;
        r.word  = '0;
        r.typed = 1'b0;
        r.want  = '0;
        r.count = COUNT_W'(n);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------

    // idle length: mostly none, some short, a few long
    function automatic int gap_len();
        int roll;
        if (no_idle) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // Offer one word, hold it until accepted, then queue its result.
    // Valid is left high so back-to-back words never drop it in one step.
    task automatic send_word(input t_in_item w, input logic typed, input t_out_item want);
        int        gap;
        t_out_item pred;
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pred = curve_step(w);
        due_words.push_back(typed ? want : pred);
    endtask

    // Drain the block, then write point_count over APB and read it back.
    // Every word has a result, so an empty queue means the block is idle.
    task automatic set_count(input logic [COUNT_W-1:0] n);
        i_in_valid <= 1'b0;
        while (due_words.size() != 0) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= COUNT_ADDR;
        pwdata  <= APB_DATA_W'(n);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        // read setup, psel stays high
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata != APB_DATA_W'(n))
            note_mismatch("point_count readback", int'(prdata), int'(n));
        psel    <= 1'b0;
        penable <= 1'b0;
        curve_count = n;
    endtask

    // ------------------------------------------------------------------
    // Receiver: checks each output word, stalls at random, and once holds
    // off for a long stretch so the block backs up into its input.
    // ------------------------------------------------------------------
    initial begin : receiver
        t_out_item want;
        int        run_left;
        bit        stalled;
        bit        held;
        run_left    = 0;
        stalled     = 1'b0;
        held        = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                words_seen++;
                if (due_words.size() == 0) begin
                    note_mismatch("word with nothing due", int'(o_out), 0);
                end else begin
                    want = due_words.pop_front();
                    if (o_out.fan_pct != want.fan_pct)
                        note_mismatch("fan_pct", int'(o_out.fan_pct), int'(want.fan_pct));
                    if (o_out.status != want.status)
                        note_mismatch("status", int'(o_out.status), int'(want.status));
                end
            end
            if (!held && words_seen >= HOLD_AFTER) begin
                held     = 1'b1;
                stalled  = 1'b1;
                run_left = HOLD_CYCLES;
            end else if (run_left <= 0) begin
                if (no_idle) begin
                    stalled  = 1'b0;
                    run_left = 1;
                end else begin
                    stalled  = ($urandom_range(0, 3) == 0);
                    run_left = stalled ? gap_len() + 1 : $urandom_range(1, 12);
                end
            end
            i_out_stall <= stalled;
            run_left--;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run when neither channel moves for too long.
    // ------------------------------------------------------------------
    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_top failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_in_item           w;
        logic [COUNT_W-1:0] n;
        int                 cur;

        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in       <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        for (int i = 0; i < NPTS; i++) begin
            curve_temp[i]  = '0;
            curve_speed[i] = '0;
        end
        curve_count = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fresh table reads as all zeros, even with every point in use
        dir_rows.push_back(count_row(16));
        dir_rows.push_back(sample_row(0, 1'b1, 0));
        dir_rows.push_back(sample_row(255, 1'b1, 0));
        // no points in use answers 0
        dir_rows.push_back(count_row(0));
        dir_rows.push_back(sample_row(128, 1'b1, 0));
        // speeds above the limit are refused and leave the table alone
        dir_rows.push_back(load_row(0, 0, 127, STS_REJECTED));
        dir_rows.push_back(load_row(0, 40, 101, STS_REJECTED));
        // rising, falling, rising, flat segments, and the top index
        dir_rows.push_back(load_row(0, 40, 20, STS_OK));
        dir_rows.push_back(load_row(1, 60, 100, STS_OK));
        dir_rows.push_back(load_row(2, 50, 80, STS_OK));
        dir_rows.push_back(load_row(3, 70, 10, STS_OK));
        dir_rows.push_back(load_row(4, 70, 90, STS_OK));
        dir_rows.push_back(load_row(15, 255, 0, STS_OK));
        dir_rows.push_back(sample_row(100, 1'b1, 0));
        // single point answers its speed everywhere
        dir_rows.push_back(count_row(1));
        dir_rows.push_back(sample_row(0, 1'b1, 20));
        dir_rows.push_back(sample_row(255, 1'b1, 20));
        // five points: clamp low, bounds, interpolation on the rising first segment,
        // upper end of the third segment, clamp high
        dir_rows.push_back(count_row(5));
        dir_rows.push_back(sample_row(30, 1'b0, 0));
        dir_rows.push_back(sample_row(40, 1'b0, 0));
        dir_rows.push_back(sample_row(53, 1'b0, 0));
        dir_rows.push_back(sample_row(60, 1'b0, 0));
        dir_rows.push_back(sample_row(55, 1'b0, 0));
        dir_rows.push_back(sample_row(70, 1'b0, 0));
        dir_rows.push_back(sample_row(200, 1'b0, 0));
        // count above the table size acts as a full table
        dir_rows.push_back(count_row(31));
        dir_rows.push_back(sample_row(255, 1'b0, 0));
        dir_rows.push_back(sample_row(71, 1'b0, 0));
        dir_rows.push_back(count_row(16));
        dir_rows.push_back(sample_row(0, 1'b0, 0));

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_COUNT)
                set_count(dir_rows[k].count);
            else
                send_word(dir_rows[k].word, dir_rows[k].typed, dir_rows[k].want);
        end

        // Random phases: new count, usually a fresh well-formed curve with a
        // little noise, then a mix of samples and stray loads.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0:       n = 5'd16;
                1:       n = 5'd2;
                2:       n = 5'd1;
                3:       n = 5'd0;
                4:       n = 5'd31;
                default: n = $urandom_range(0, 1) ? COUNT_W'($urandom_range(2, 16))
                                                  : COUNT_W'($urandom_range(0, 31));
            endcase
            set_count(n);
            no_idle = (ph % 4 == 1);

            if (ph == 0 || $urandom_range(0, 3) != 0) begin
                cur = $urandom_range(0, 20);
                for (int k = 0; k < NPTS; k++) begin
                    w                   = t_in_item'(IN_W'($urandom));
                    w.action            = ACT_LOAD;
                    w.point_index       = INDEX_W'(k);
                    w.point_temperature = TEMP_W'(cur);
                    w.point_pct         = SPEED_W'($urandom_range(0, 100));
                    if ($urandom_range(0, 9) == 0)
                        w.point_pct = SPEED_W'($urandom_range(101, 127));
                    if ($urandom_range(0, 9) == 0)
                        w.point_temperature = TEMP_W'($urandom_range(0, 255));
                    send_word(w, 1'b0, '0);
                    // mostly rising, some repeated temperatures
                    cur += ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 28);
                    if (cur > 255) cur = 255;
                end
            end

            for (int k = 0; k < PHASE_WORDS; k++) begin
                w = t_in_item'(IN_W'($urandom));
                if ($urandom_range(0, 9) < 7) begin
                    w.action = ACT_SAMPLE;
                    // land on breakpoints now and then
                    if ($urandom_range(0, 3) == 0)
                        w.temperature = curve_temp[$urandom_range(0, NPTS - 1)];
                end else begin
                    w.action = ACT_LOAD;
                    if ($urandom_range(0, 5) != 0)
                        w.point_pct = SPEED_W'($urandom_range(0, 100));
                end
                send_word(w, 1'b0, '0);
            end
        end
        no_idle = 1'b0;

        i_in_valid <= 1'b0;
        while (due_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/fcurve_pkg.sv
src/fcurve_ram.sv
src/fcurve_ctrl.sv
src/fcurve_dp.sv
src/fan_curve_interpolator_unit.sv
sim/tb_top.sv
